// ===== hdl/hrhp_pkg.sv =====
// Package for the HTTP response head parser: widths, codes, phase type
// and the header-name table. No dependencies.

package hrhp_pkg;

   localparam int NumberBits = 31;
   localparam int NameLen    = 14;

   localparam logic [7:0] ChrSpace = 8'h20;
   localparam logic [7:0] ChrColon = 8'h3A;
   localparam logic [7:0] ChrCr    = 8'h0D;
   localparam logic [7:0] ChrLf    = 8'h0A;
   localparam logic [7:0] ChrNul   = 8'h00;
   localparam logic [7:0] ChrZero  = 8'h30;
   localparam logic [7:0] ChrNine  = 8'h39;

   localparam logic [1:0] KIND_HEAD_DONE = 2'd0;
   localparam logic [1:0] KIND_BODY      = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_NO_LF     = 2'd1;
   localparam logic [1:0] ERR_NON_DIGIT = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

   typedef logic [NumberBits-1:0] number_type;
   typedef logic [3:0]            name_pos_type;

   typedef enum logic [7:0] {
      PH_VERSION = 8'b0000_0001,
      PH_CODE    = 8'b0000_0010,
      PH_REASON  = 8'b0000_0100,
      PH_NAME    = 8'b0000_1000,
      PH_VALUE   = 8'b0001_0000,
      PH_BODY    = 8'b0010_0000,
      PH_DONE    = 8'b0100_0000,
      PH_ERROR   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic       is_digit;
      logic       overflow;
      number_type value;
   } digit_step_type;

   function automatic logic [7:0] name_char(input name_pos_type pos);
      logic [7:0] c;
      c = ChrNul;
      case (pos)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h4C; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         default: c = ChrNul;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/hrhp_req_if.sv =====
// Input channel of the response head parser: one stream byte per word.
// Depends on nothing.

interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hdl/hrhp_rsp_if.sv =====
// Result channel of the response head parser: one result per word.
// Depends on nothing.

interface hrhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [30:0] status_code;
   logic [30:0] body_length;
   logic [7:0]  body_byte;
   logic        last;
   logic [1:0]  error_code;

   modport source (output valid, output kind, output status_code, output body_length,
                   output body_byte, output last, output error_code, input ready);
   modport sink   (input valid, input kind, input status_code, input body_length,
                   input body_byte, input last, input error_code, output ready);
endinterface

// ===== hdl/hrhp_digit_acc.sv =====
// Decimal accumulate step: times ten plus one digit, with range check.
// Depends on hrhp_pkg.

module hrhp_digit_acc (
   input  hrhp_pkg::number_type     acc,
   input  logic [7:0]               data_byte,
   output hrhp_pkg::digit_step_type step
);

   localparam int WideBits = hrhp_pkg::NumberBits + 4;

   logic [WideBits-1:0] times_ten;
   logic [WideBits-1:0] sum;
   logic [3:0]          digit;

   assign digit     = 4'(data_byte - hrhp_pkg::ChrZero);
   assign times_ten = (WideBits'(acc) << 3) + (WideBits'(acc) << 1);
   assign sum       = times_ten + WideBits'(digit);

   assign step.is_digit = (data_byte >= hrhp_pkg::ChrZero) &&
                          (data_byte <= hrhp_pkg::ChrNine);
   assign step.overflow = |sum[WideBits-1:hrhp_pkg::NumberBits];
   assign step.value    = sum[hrhp_pkg::NumberBits-1:0];

endmodule

// ===== hdl/http_response_head_parser_core.sv =====
// Top level of the HTTP response head parser: status line, headers, body.
// Depends on hrhp_pkg, hrhp_req_if, hrhp_rsp_if and hrhp_digit_acc.
//
//   channel  direction  word
//   req_if   in         data_byte
//   rsp_if   out        kind, status_code, body_length, body_byte, last, error_code
//
// One byte per cycle sustained while results are drained; a byte passes the input
// register, then the result register loaded by the phase logic.
// Reset clears all parser state; the parser then expects the version field.
// A held result stalls the input register and the phase logic; a new byte is taken in the cycle
// the result is drained.

module http_response_head_parser_core (
   input logic        clock,
   input logic        reset,
   hrhp_req_if.sink   req_if,
   hrhp_rsp_if.source rsp_if
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 advance;

   hrhp_pkg::phase_type    phase_ff, phase_in;
   logic                   await_lf_ff, await_lf_in;
   logic                   has_bytes_ff, has_bytes_in;
   hrhp_pkg::number_type   accum_ff, accum_in;
   hrhp_pkg::number_type   code_ff, code_in;
   hrhp_pkg::number_type   length_ff, length_in;
   hrhp_pkg::name_pos_type pos_ff, pos_in;
   logic                   matches_ff, matches_in;
   logic                   lead_done_ff, lead_done_in;
   hrhp_pkg::number_type   remain_ff, remain_in;

   logic                 rsp_valid_ff;
   logic [1:0]           kind_ff, kind_in;
   hrhp_pkg::number_type status_ff, status_in;
   hrhp_pkg::number_type blen_ff, blen_in;
   logic [7:0]           bbyte_ff, bbyte_in;
   logic                 last_ff, last_in;
   logic [1:0]           err_ff, err_in;
   logic                 res_load;

   hrhp_pkg::digit_step_type dstep;
   logic                     finish;
   logic                     fail;
   logic [1:0]               fail_code;
   logic                     name_full;

   hrhp_digit_acc u_digit (
      .acc       (accum_ff),
      .data_byte (in_byte_ff),
      .step      (dstep)
   );

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready   = !in_valid_ff || advance;
   assign name_full      = matches_ff && (pos_ff == hrhp_pkg::name_pos_type'(hrhp_pkg::NameLen));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.data_byte;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      await_lf_in  = await_lf_ff;
      has_bytes_in = has_bytes_ff;
      accum_in     = accum_ff;
      code_in      = code_ff;
      length_in    = length_ff;
      pos_in       = pos_ff;
      matches_in   = matches_ff;
      lead_done_in = lead_done_ff;
      remain_in    = remain_ff;
      res_load     = 1'b0;
      kind_in      = hrhp_pkg::KIND_BODY;
      status_in    = code_ff;
      blen_in      = length_ff;
      bbyte_in     = in_byte_ff;
      last_in      = 1'b0;
      err_in       = hrhp_pkg::ERR_NONE;
      finish       = 1'b0;
      fail         = 1'b0;
      fail_code    = hrhp_pkg::ERR_NONE;

      if (advance) begin
         unique case (phase_ff)
            hrhp_pkg::PH_BODY: begin
               res_load = 1'b1;
               last_in  = (remain_ff <= hrhp_pkg::number_type'(1));
               if (last_in) begin
                  remain_in = '0;
                  phase_in  = hrhp_pkg::PH_DONE;
               end else begin
                  remain_in = remain_ff - hrhp_pkg::number_type'(1);
               end
            end
            hrhp_pkg::PH_DONE, hrhp_pkg::PH_ERROR: begin
            end
            default: begin
               if (await_lf_ff) begin
                  await_lf_in = 1'b0;
                  if (in_byte_ff != hrhp_pkg::ChrLf) begin
                     fail      = 1'b1;
                     fail_code = hrhp_pkg::ERR_NO_LF;
                  end else begin
                     finish = 1'b1;
                  end
               end else if (in_byte_ff == hrhp_pkg::ChrCr) begin
                  await_lf_in = 1'b1;
               end else begin
                  unique case (phase_ff)
                     hrhp_pkg::PH_VERSION: begin
                        finish = (in_byte_ff == hrhp_pkg::ChrSpace);
                     end
                     hrhp_pkg::PH_CODE: begin
                        if (in_byte_ff == hrhp_pkg::ChrSpace) begin
                           finish = 1'b1;
                        end else if (!dstep.is_digit) begin
                           fail      = 1'b1;
                           fail_code = hrhp_pkg::ERR_NON_DIGIT;
                        end else if (dstep.overflow) begin
                           fail      = 1'b1;
                           fail_code = hrhp_pkg::ERR_OVERFLOW;
                        end else begin
                           accum_in = dstep.value;
                        end
                     end
                     hrhp_pkg::PH_REASON: begin
                        finish = (in_byte_ff == hrhp_pkg::ChrNul);
                     end
                     hrhp_pkg::PH_NAME: begin
                        if (in_byte_ff == hrhp_pkg::ChrColon) begin
                           finish = 1'b1;
                        end else begin
                           has_bytes_in = 1'b1;
                           if (matches_ff &&
                               (pos_ff < hrhp_pkg::name_pos_type'(hrhp_pkg::NameLen)) &&
                               (in_byte_ff == hrhp_pkg::name_char(pos_ff))) begin
                              pos_in = pos_ff + 4'd1;
                           end else begin
                              matches_in = 1'b0;
                           end
                        end
                     end
                     default: begin
                        if (in_byte_ff == hrhp_pkg::ChrNul) begin
                           finish = 1'b1;
                        end else if (lead_done_ff || (in_byte_ff != hrhp_pkg::ChrSpace)) begin
                           lead_done_in = 1'b1;
                           if (name_full) begin
                              if (!dstep.is_digit) begin
                                 fail      = 1'b1;
                                 fail_code = hrhp_pkg::ERR_NON_DIGIT;
                              end else if (dstep.overflow) begin
                                 fail      = 1'b1;
                                 fail_code = hrhp_pkg::ERR_OVERFLOW;
                              end else begin
                                 accum_in = dstep.value;
                              end
                           end
                        end
                     end
                  endcase
               end
            end
         endcase

         if (fail) begin
            phase_in  = hrhp_pkg::PH_ERROR;
            res_load  = 1'b1;
            kind_in   = hrhp_pkg::KIND_ERROR;
            status_in = '0;
            blen_in   = '0;
            bbyte_in  = '0;
            err_in    = fail_code;
         end else if (finish) begin
            unique case (phase_ff)
               hrhp_pkg::PH_VERSION: begin
                  phase_in = hrhp_pkg::PH_CODE;
                  accum_in = '0;
               end
               hrhp_pkg::PH_CODE: begin
                  code_in  = accum_ff;
                  phase_in = hrhp_pkg::PH_REASON;
               end
               hrhp_pkg::PH_NAME: begin
                  if (!has_bytes_ff) begin
                     remain_in = length_ff;
                     phase_in  = (length_ff == '0) ? hrhp_pkg::PH_DONE : hrhp_pkg::PH_BODY;
                     res_load  = 1'b1;
                     kind_in   = hrhp_pkg::KIND_HEAD_DONE;
                     bbyte_in  = '0;
                     last_in   = (length_ff == '0);
                  end else begin
                     phase_in     = hrhp_pkg::PH_VALUE;
                     accum_in     = '0;
                     lead_done_in = 1'b0;
                  end
               end
               default: begin
                  if ((phase_ff == hrhp_pkg::PH_VALUE) && name_full) begin
                     length_in = accum_ff;
                  end
                  phase_in     = hrhp_pkg::PH_NAME;
                  pos_in       = '0;
                  matches_in   = 1'b1;
                  has_bytes_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hrhp_pkg::PH_VERSION;
         await_lf_ff  <= 1'b0;
         has_bytes_ff <= 1'b0;
         accum_ff     <= '0;
         code_ff      <= '0;
         length_ff    <= '0;
         pos_ff       <= '0;
         matches_ff   <= 1'b1;
         lead_done_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         await_lf_ff  <= await_lf_in;
         has_bytes_ff <= has_bytes_in;
         accum_ff     <= accum_in;
         code_ff      <= code_in;
         length_ff    <= length_in;
         pos_ff       <= pos_in;
         matches_ff   <= matches_in;
         lead_done_ff <= lead_done_in;
         remain_ff    <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         blen_ff   <= blen_in;
         bbyte_ff  <= bbyte_in;
         last_ff   <= last_in;
         err_ff    <= err_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.kind        = kind_ff;
   assign rsp_if.status_code = status_ff;
   assign rsp_if.body_length = blen_ff;
   assign rsp_if.body_byte   = bbyte_ff;
   assign rsp_if.last        = last_ff;
   assign rsp_if.error_code  = err_ff;

`ifndef ASSERT_OFF
   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.kind == hrhp_pkg::KIND_ERROR)) |->
         (rsp_if.error_code != hrhp_pkg::ERR_NONE))
      else $error("error word without error code");

   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == hrhp_pkg::PH_DONE) || (phase_ff == hrhp_pkg::PH_ERROR)) |-> !res_load)
      else $error("result produced after end of stream");

   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hrhp_pkg::PH_BODY) |-> (remain_ff != '0))
      else $error("body phase with nothing remaining");

   a_lf_wait_in_head: assert property (@(posedge clock) disable iff (reset)
      await_lf_ff |-> ((phase_ff != hrhp_pkg::PH_BODY) && (phase_ff != hrhp_pkg::PH_DONE) &&
                       (phase_ff != hrhp_pkg::PH_ERROR)))
      else $error("line feed wait outside the head");
`endif

endmodule
